// ----- src/kmer_contaminant_screen_unit_defines.svh -----
// ----------------------------------------------------------------------------
// kmer_contaminant_screen_unit_defines.svh
// Assertion macros for the k-mer contaminant screen.
// ----------------------------------------------------------------------------
`ifndef KMER_CONTAMINANT_SCREEN_UNIT_DEFINES_SVH
`define KMER_CONTAMINANT_SCREEN_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KCS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("kcs: implication failed");
// next-cycle implication
`define KCS_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("kcs: next-cycle implication failed");
`else
`define KCS_ASSERT_IMP(label, clk, rst_n, a, b)
`define KCS_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- src/kcs_pkg.sv -----
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types and constants of the k-mer contaminant screen.
// ----------------------------------------------------------------------------
package kcs_pkg;

    localparam int MAX_KMER_DEF      = 32;
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CONT_DEF      = 32;

    localparam int KEY_W  = 64;
    localparam int MASK_W = 32;
    localparam int CNT_W  = 40;
    localparam int KLEN_W = 6;
    localparam int SEQ_W  = 6;
    localparam int CIDX_W = 5;
    localparam int NCNT   = 32;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd20;

    // ASCII bases (upper case) and lower-case range
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // BAM nibbles
    localparam logic [3:0] BAM_A = 4'h1;
    localparam logic [3:0] BAM_C = 4'h2;
    localparam logic [3:0] BAM_G = 4'h4;
    localparam logic [3:0] BAM_T = 4'h8;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic {
        REPLY_READ  = 1'b0,
        REPLY_COUNT = 1'b1
    } t_reply;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_UPDATE,
        S_FINISH,
        S_COUNT,
        S_EMIT
    } t_state;

    // counter bank request
    typedef struct packed {
        logic              inc;
        logic [CIDX_W-1:0] idx;
    } t_cnt_req;

endpackage

// ----- src/kcs_if.sv -----
// ----------------------------------------------------------------------------
// kcs_if
// Channel interfaces: input word, result word, configuration write.
// ----------------------------------------------------------------------------
interface kcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] letter;
    logic [3:0] bam_code;
    logic       is_last;
    logic [4:0] contaminant_index;
    modport source (output valid, action, letter, bam_code, is_last, contaminant_index,
                    input ready);
    modport sink   (input valid, action, letter, bam_code, is_last, contaminant_index,
                    output ready);
endinterface

interface kcs_out_if;
    logic        valid;
    logic        ready;
    logic        reply_kind;
    logic [31:0] hit_mask;
    logic [39:0] reads_seen;
    logic [39:0] shared_count;
    logic        overflow;
    modport source (output valid, reply_kind, hit_mask, reads_seen, shared_count, overflow,
                    input ready);
    modport sink   (input valid, reply_kind, hit_mask, reads_seen, shared_count, overflow,
                    output ready);
endinterface

interface kcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/kcs_table.sv -----
// ----------------------------------------------------------------------------
// kcs_table
// K-mer key and contaminant mask memories, one write and one registered read.
// ----------------------------------------------------------------------------
module kcs_table #(
    parameter int TABLE_ENTRIES = kcs_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  i_rd_addr,
    input  logic                              i_wr_en,
    input  logic                              i_wr_key_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  i_wr_addr,
    input  logic [kcs_pkg::KEY_W-1:0]         i_wr_key,
    input  logic [kcs_pkg::MASK_W-1:0]        i_wr_mask,
    output logic [kcs_pkg::KEY_W-1:0]         o_rd_key,
    output logic [kcs_pkg::MASK_W-1:0]        o_rd_mask
);
    logic [kcs_pkg::KEY_W-1:0]  r_keys  [TABLE_ENTRIES];
    logic [kcs_pkg::MASK_W-1:0] r_masks [TABLE_ENTRIES];

    // key store: written only when a new entry is made
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_key_en) begin
            r_keys[i_wr_addr] <= i_wr_key;
        end
        if (i_rd_en) begin
            o_rd_key <= r_keys[i_rd_addr];
        end
    end

    // mask store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_masks[i_wr_addr] <= i_wr_mask;
        end
        if (i_rd_en) begin
            o_rd_mask <= r_masks[i_rd_addr];
        end
    end
endmodule

// ----- src/kcs_counters.sv -----
// ----------------------------------------------------------------------------
// kcs_counters
// Per-contaminant hit counters with one shared 40-bit incrementer.
// ----------------------------------------------------------------------------
module kcs_counters (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kcs_pkg::t_cnt_req         i_req,
    output logic [kcs_pkg::CNT_W-1:0] o_count
);
    logic [kcs_pkg::CNT_W-1:0] r_cnt [kcs_pkg::NCNT];

    assign o_count = r_cnt[i_req.idx];

    // one counter bumped per cycle, wrapping at 40 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kcs_pkg::NCNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_req.inc) begin
            r_cnt[i_req.idx] <= r_cnt[i_req.idx] + kcs_pkg::CNT_W'(1);
        end
    end
endmodule

// ----- src/kmer_contaminant_screen_unit.sv -----
// ----------------------------------------------------------------------------
// kmer_contaminant_screen_unit
// K-mer set membership screen of reads against loaded contaminant sequences.
//
//   channel   dir  handshake      payload
//   i_item    in   valid/ready    action, letter, bam_code, is_last, contaminant_index
//   o_result  out  valid/ready    reply_kind, hit_mask, reads_seen, shared_count, overflow
//   i_cfg     in   valid/ready    data (kmer_length)
//
// Each lookup scans the key memory linearly, a registered read and then a compare
// per stored entry. A base passes through accept, prep and finish, plus a search
// per key when the window is full; a load base searches two keys (forward, then reverse complement).
// Read end adds a sweep of the 32 counters, then emit. A count query is prep, then emit.
// Reset is synchronous; no clearing pass, only entries below the fill count are read.
// A result waiting in o_result holds the next result in emit, and input waits with it.
// ----------------------------------------------------------------------------
`include "kmer_contaminant_screen_unit_defines.svh"

module kmer_contaminant_screen_unit #(
    parameter int MAX_KMER         = kcs_pkg::MAX_KMER_DEF,
    parameter int TABLE_ENTRIES    = kcs_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CONTAMINANTS = kcs_pkg::MAX_CONT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcs_in_if.sink    i_item,
    kcs_out_if.source o_result,
    kcs_cfg_if.sink   i_cfg
);
    localparam int AW       = $clog2(TABLE_ENTRIES);
    localparam int UW       = $clog2(TABLE_ENTRIES + 1);
    localparam int ID_SLOTS = (MAX_CONTAMINANTS < 32) ? MAX_CONTAMINANTS : 32;
    localparam int KW       = kcs_pkg::KEY_W;
    localparam int LW       = kcs_pkg::KLEN_W;

    kcs_pkg::t_state r_state, n_state;

    logic [LW-1:0]              r_klen;
    logic [KW-1:0]              r_fwin, r_rwin;
    logic [5:0]                 r_run;
    logic [UW-1:0]              r_used;
    logic [kcs_pkg::SEQ_W-1:0]  r_seq;
    logic [kcs_pkg::MASK_W-1:0] r_hits;
    logic [kcs_pkg::CNT_W-1:0]  r_total;
    logic                       r_overflow;

    kcs_pkg::t_action           r_act;
    logic                       r_last, r_code_ok, r_phase, r_found;
    logic [kcs_pkg::CIDX_W-1:0] r_idx, r_ci;
    logic [KW-1:0]              r_key, r_key_rc;
    logic [UW-1:0]              r_ptr;

    logic                        r_out_valid, r_out_kind, r_out_ovf;
    logic [kcs_pkg::MASK_W-1:0]  r_out_hits;
    logic [kcs_pkg::CNT_W-1:0]   r_out_total, r_out_shared;

    logic [KW-1:0]              tbl_key;
    logic [kcs_pkg::MASK_W-1:0] tbl_mask;
    logic                       tbl_rd_en, tbl_wr_en, tbl_wr_key_en;
    logic [AW-1:0]              tbl_wr_addr;
    logic [kcs_pkg::MASK_W-1:0] tbl_wr_mask;
    kcs_pkg::t_cnt_req          cnt_req;
    logic [kcs_pkg::CNT_W-1:0]  cnt_val;

    logic                       in_fire, out_free, search_ok;
    logic [1:0]                 dec_code;
    logic                       dec_ok;
    logic [7:0]                 up_letter;
    logic [LW-1:0]              eff_k;
    logic [6:0]                 two_k;
    logic [KW-1:0]              fwd_key, rc_key;
    logic [kcs_pkg::MASK_W-1:0] seq_bit;

    assign in_fire  = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign i_cfg.ready = 1'b1;
    assign i_item.ready = (r_state == kcs_pkg::S_IDLE);

    // base decode
    always_comb begin
        up_letter = i_item.letter;
        if (i_item.letter >= kcs_pkg::CH_LO_A && i_item.letter <= kcs_pkg::CH_LO_Z) begin
            up_letter = i_item.letter - kcs_pkg::CASE_OFS;
        end
        dec_ok   = 1'b1;
        dec_code = 2'd0;
        if (i_item.action == kcs_pkg::ACT_LOAD) begin
            priority if (up_letter == kcs_pkg::CH_A) dec_code = 2'd0;
            else if (up_letter == kcs_pkg::CH_C) dec_code = 2'd1;
            else if (up_letter == kcs_pkg::CH_G) dec_code = 2'd2;
            else if (up_letter == kcs_pkg::CH_T) dec_code = 2'd3;
            else dec_ok = 1'b0;
        end else begin
            priority if (i_item.bam_code == kcs_pkg::BAM_A) dec_code = 2'd0;
            else if (i_item.bam_code == kcs_pkg::BAM_C) dec_code = 2'd1;
            else if (i_item.bam_code == kcs_pkg::BAM_G) dec_code = 2'd2;
            else if (i_item.bam_code == kcs_pkg::BAM_T) dec_code = 2'd3;
            else dec_ok = 1'b0;
        end
    end

    // effective k and key extraction from the current windows
    always_comb begin
        eff_k = r_klen;
        if (r_klen == '0) eff_k = LW'(1);
        if (r_klen > LW'(MAX_KMER)) eff_k = LW'(MAX_KMER);
        two_k = {eff_k, 1'b0};
        if (two_k >= 7'd64) fwd_key = r_fwin;
        else fwd_key = r_fwin & ((KW'(1) << two_k) - KW'(1));
        rc_key = r_rwin >> (7'd64 - two_k);
        seq_bit = kcs_pkg::MASK_W'(1) << r_seq[4:0];
    end

    assign search_ok = r_code_ok && (r_run >= eff_k);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kcs_pkg::S_IDLE: begin
                if (in_fire) n_state = kcs_pkg::S_PREP;
            end
            kcs_pkg::S_PREP: begin
                unique case (r_act)
                    kcs_pkg::ACT_LOAD: begin
                        if (r_seq < kcs_pkg::SEQ_W'(ID_SLOTS) && search_ok)
                            n_state = kcs_pkg::S_SRCH_RD;
                        else n_state = kcs_pkg::S_FINISH;
                    end
                    kcs_pkg::ACT_READ: begin
                        n_state = search_ok ? kcs_pkg::S_SRCH_RD : kcs_pkg::S_FINISH;
                    end
                    kcs_pkg::ACT_COUNT: n_state = kcs_pkg::S_EMIT;
                    default:            n_state = kcs_pkg::S_IDLE;
                endcase
            end
            kcs_pkg::S_SRCH_RD: begin
                n_state = (r_ptr == r_used) ? kcs_pkg::S_UPDATE : kcs_pkg::S_SRCH_CMP;
            end
            kcs_pkg::S_SRCH_CMP: begin
                if (tbl_key == r_key) n_state = kcs_pkg::S_UPDATE;
                else n_state = kcs_pkg::S_SRCH_RD;
            end
            kcs_pkg::S_UPDATE: begin
                if (r_act == kcs_pkg::ACT_LOAD && !r_phase) n_state = kcs_pkg::S_SRCH_RD;
                else n_state = kcs_pkg::S_FINISH;
            end
            kcs_pkg::S_FINISH: begin
                if (r_act == kcs_pkg::ACT_READ && r_last) n_state = kcs_pkg::S_COUNT;
                else n_state = kcs_pkg::S_IDLE;
            end
            kcs_pkg::S_COUNT: begin
                if (r_ci == kcs_pkg::CIDX_W'(kcs_pkg::NCNT - 1)) n_state = kcs_pkg::S_EMIT;
            end
            kcs_pkg::S_EMIT: begin
                if (out_free) n_state = kcs_pkg::S_IDLE;
            end
            default: n_state = kcs_pkg::S_IDLE;
        endcase
    end

    // memory and counter controls
    always_comb begin
        tbl_rd_en     = (r_state == kcs_pkg::S_SRCH_RD) && (r_ptr != r_used);
        tbl_wr_en     = 1'b0;
        tbl_wr_key_en = 1'b0;
        tbl_wr_addr   = r_ptr[AW-1:0];
        tbl_wr_mask   = tbl_mask | seq_bit;
        if (r_state == kcs_pkg::S_UPDATE && r_act == kcs_pkg::ACT_LOAD) begin
            if (r_found) begin
                tbl_wr_en = 1'b1;
            end else if (r_used < UW'(TABLE_ENTRIES)) begin
                tbl_wr_en     = 1'b1;
                tbl_wr_key_en = 1'b1;
                tbl_wr_addr   = r_used[AW-1:0];
                tbl_wr_mask   = seq_bit;
            end
        end
        cnt_req.inc = (r_state == kcs_pkg::S_COUNT) && r_hits[r_ci];
        cnt_req.idx = (r_state == kcs_pkg::S_COUNT) ? r_ci : r_idx;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= kcs_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen      <= kcs_pkg::KLEN_RESET;
            r_fwin      <= '0;
            r_rwin      <= '0;
            r_run       <= '0;
            r_used      <= '0;
            r_seq       <= '0;
            r_hits      <= '0;
            r_total     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) r_klen <= i_cfg.data;
            // the emit state reloads the result word itself
            if (r_out_valid && o_result.ready && r_state != kcs_pkg::S_EMIT)
                r_out_valid <= 1'b0;

            unique case (r_state)
                kcs_pkg::S_IDLE: begin
                    if (in_fire) begin
                        r_act     <= kcs_pkg::t_action'(i_item.action);
                        r_last    <= i_item.is_last;
                        r_idx     <= i_item.contaminant_index;
                        r_code_ok <= dec_ok;
                        if (i_item.action == kcs_pkg::ACT_LOAD ||
                            i_item.action == kcs_pkg::ACT_READ) begin
                            if (dec_ok) begin
                                r_fwin <= {r_fwin[KW-3:0], dec_code};
                                r_rwin <= {~dec_code, r_rwin[KW-1:2]};
                                if (r_run != 6'd63) r_run <= r_run + 6'd1;
                            end else begin
                                r_run <= '0;
                            end
                        end
                    end
                end
                kcs_pkg::S_PREP: begin
                    r_key    <= fwd_key;
                    r_key_rc <= rc_key;
                    r_phase  <= 1'b0;
                    r_ptr    <= '0;
                    if (r_act == kcs_pkg::ACT_LOAD && r_seq >= kcs_pkg::SEQ_W'(ID_SLOTS))
                        r_overflow <= 1'b1;
                end
                kcs_pkg::S_SRCH_RD: begin
                    r_found <= 1'b0;
                end
                kcs_pkg::S_SRCH_CMP: begin
                    if (tbl_key == r_key) r_found <= 1'b1;
                    else r_ptr <= r_ptr + UW'(1);
                end
                kcs_pkg::S_UPDATE: begin
                    if (r_act == kcs_pkg::ACT_LOAD) begin
                        if (!r_found) begin
                            if (r_used < UW'(TABLE_ENTRIES)) r_used <= r_used + UW'(1);
                            else r_overflow <= 1'b1;
                        end
                        r_key   <= r_key_rc;
                        r_phase <= 1'b1;
                        r_ptr   <= '0;
                    end else if (r_found) begin
                        r_hits <= r_hits | tbl_mask;
                    end
                end
                kcs_pkg::S_FINISH: begin
                    r_ci <= '0;
                    if (r_last) begin
                        if (r_act == kcs_pkg::ACT_LOAD) begin
                            if (r_seq != 6'd63) r_seq <= r_seq + 6'd1;
                            r_fwin <= '0;
                            r_rwin <= '0;
                            r_run  <= '0;
                        end else begin
                            r_total <= r_total + kcs_pkg::CNT_W'(1);
                        end
                    end
                end
                kcs_pkg::S_COUNT: begin
                    r_ci <= r_ci + kcs_pkg::CIDX_W'(1);
                end
                kcs_pkg::S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_total <= r_total;
                        r_out_ovf   <= r_overflow;
                        if (r_act == kcs_pkg::ACT_COUNT) begin
                            r_out_kind   <= kcs_pkg::REPLY_COUNT;
                            r_out_hits   <= '0;
                            r_out_shared <= (r_idx < kcs_pkg::CIDX_W'(ID_SLOTS) ||
                                             ID_SLOTS == 32) ? cnt_val : '0;
                        end else begin
                            r_out_kind   <= kcs_pkg::REPLY_READ;
                            r_out_hits   <= r_hits;
                            r_out_shared <= '0;
                            r_hits       <= '0;
                            r_fwin       <= '0;
                            r_rwin       <= '0;
                            r_run        <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    kcs_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rd_en     (tbl_rd_en),
        .i_rd_addr   (r_ptr[AW-1:0]),
        .i_wr_en     (tbl_wr_en),
        .i_wr_key_en (tbl_wr_key_en),
        .i_wr_addr   (tbl_wr_addr),
        .i_wr_key    (r_key),
        .i_wr_mask   (tbl_wr_mask),
        .o_rd_key    (tbl_key),
        .o_rd_mask   (tbl_mask)
    );

    kcs_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cnt_req),
        .o_count (cnt_val)
    );

    // result word
    assign o_result.valid        = r_out_valid;
    assign o_result.reply_kind   = r_out_kind;
    assign o_result.hit_mask     = r_out_hits;
    assign o_result.reads_seen   = r_out_total;
    assign o_result.shared_count = r_out_shared;
    assign o_result.overflow     = r_out_ovf;

    // checks
    `KCS_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= UW'(TABLE_ENTRIES))
    `KCS_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == kcs_pkg::S_SRCH_CMP, r_ptr < r_used)
    `KCS_ASSERT_NXT(a_ovf_sticky, i_clk, i_rst_n, r_overflow, r_overflow)
    `KCS_ASSERT_IMP(a_busy_hold, i_clk, i_rst_n, r_state != kcs_pkg::S_IDLE, !i_item.ready)
endmodule
